// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the list unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every clock edge outside reset.
`define OVL_CHECK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checks that a condition in one cycle leads to a consequence in the next.
`define OVL_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ovl_pkg.sv =====
// Types and codes shared by the ordered value list unit.
`default_nettype none

package ovl_pkg;

    // Command codes.
    localparam logic [1:0] CMD_APPEND = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_FIND   = 2'd2;

    // Status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_BOUND     = 3'd4;

    // One command item.
    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] item_value;
        logic [7:0]         offset_from_end;
    } req_t;

    // One result item.
    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] found_value;
        logic [4:0]         entry_total;
    } rsp_t;

    // Controls broadcast from the sequencer to every cell.
    typedef struct packed {
        logic               exec;
        logic               apply_append;
        logic               apply_delete;
        logic signed [31:0] item_value;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/ovl_cell.sv =====
// One list cell: holds one entry, compares it and shifts from its neighbor.
`default_nettype none

module ovl_cell #(
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  wire                logic clk,
    input  wire ovl_pkg::cell_ctl_t  ctl,
    input  wire                logic [CW-1:0] count,
    input  wire                logic [CW-1:0] target,
    input  wire                logic shift_en,
    input  wire                logic signed [31:0] neighbor_value,
    output                     logic signed [31:0] value,
    output                     logic match,
    output                     logic signed [31:0] sel_value
);

    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    logic               match_reg;
    logic               match_next;
    logic signed [31:0] sel_reg;
    logic signed [31:0] sel_next;
    logic               occupied;
    logic               at_tail;

    // The cell holds a live entry when its place is below the count.
    assign occupied = (CW'(IDX) < count);
    assign at_tail  = (CW'(IDX) == count);

    // Compare stage records the match and the selected value; apply stage
    // writes an appended item or takes the neighbor's entry.
    always_comb
    begin
        match_next = match_reg;
        sel_next   = sel_reg;
        value_next = value_reg;
        if (ctl.exec)
        begin
            match_next = occupied && (value_reg == ctl.item_value);
            sel_next   = (CW'(IDX) == target) ? value_reg : '0;
        end
        if (ctl.apply_append && at_tail)
        begin
            value_next = ctl.item_value;
        end
        else if (ctl.apply_delete && shift_en)
        begin
            value_next = neighbor_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        match_reg <= match_next;
        sel_reg   <= sel_next;
    end

    assign value     = value_reg;
    assign match     = match_reg;
    assign sel_value = sel_reg;

endmodule

`default_nettype wire

// ===== rtl/core/ordered_value_list_unit.sv =====
// An item passes through the accept cycle, the compare stage in the cells and
// the compaction stage in that order, and its result is registered as the
// compaction stage ends; the unit takes no new item until then, and a stalled
// result holds the unit in its last stage.
// Reset clears the entry count, so the list starts empty; entry storage is
// not cleared and there is no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module ordered_value_list_unit #(
    parameter int DEPTH = 16
) (
    input  wire             logic clk,
    input  wire             logic rst_n,
    input  wire             logic req_valid,
    output                  logic req_stall,
    input  wire ovl_pkg::req_t    req,
    output                  logic rsp_valid,
    input  wire             logic rsp_stall,
    output ovl_pkg::rsp_t         rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = (CW > 8) ? CW : 8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FINISH
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [1:0]         cmd_reg;
    logic [1:0]         cmd_next;
    logic signed [31:0] item_reg;
    logic signed [31:0] item_next;
    logic [7:0]         k_reg;
    logic [7:0]         k_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    ovl_pkg::rsp_t      rsp_reg;
    ovl_pkg::rsp_t      rsp_next;

    logic               accept;
    logic               finish_go;
    logic [CW-1:0]      target;
    logic [DEPTH-1:0]   match_vec;
    logic [DEPTH-1:0]   shift_vec;
    logic               any_match;
    logic signed [31:0] cell_value [DEPTH];
    logic signed [31:0] cell_sel [DEPTH];
    logic signed [31:0] found_or;
    ovl_pkg::cell_ctl_t ctl;

    // Handshake: one item at a time; results wait in the output register.
    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign finish_go = (state_reg == S_FINISH) && (!rsp_valid_reg || !rsp_stall);

    // Position of the k-th entry from the end; used only when k is in range.
    assign target = count_reg - CW'(1) - CW'(k_reg);

    // Broadcast controls for the cells.
    always_comb
    begin
        ctl.exec         = (state_reg == S_EXEC);
        ctl.apply_append = finish_go && (cmd_reg == ovl_pkg::CMD_APPEND);
        ctl.apply_delete = finish_go && (cmd_reg == ovl_pkg::CMD_DELETE);
        ctl.item_value   = item_reg;
    end

    // The row of cells; each takes the next cell's entry when compacting.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [31:0] nb;
        if (i == DEPTH - 1)
        begin : g_last
            assign nb = cell_value[i];
        end
        else
        begin : g_inner
            assign nb = cell_value[i + 1];
        end

        ovl_cell #(
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .clk            (clk),
            .ctl            (ctl),
            .count          (count_reg),
            .target         (target),
            .shift_en       (shift_vec[i]),
            .neighbor_value (nb),
            .value          (cell_value[i]),
            .match          (match_vec[i]),
            .sel_value      (cell_sel[i])
        );
    end

    // Cells at and above the first match shift; the match vector ORed with
    // its negation sets every bit from the lowest match upward.
    assign shift_vec = match_vec | ((~match_vec) + DEPTH'(1));
    assign any_match = |match_vec;

    // Only the selected cell gives a nonzero value, so an OR collects it.
    always_comb
    begin
        found_or = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            found_or = found_or | cell_sel[i];
        end
    end

    // Sequencer and output register next values.
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        item_next      = item_reg;
        k_next         = k_reg;
        count_next     = count_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = req.cmd;
                    item_next  = req.item_value;
                    k_next     = req.offset_from_end;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (finish_go)
                begin
                    rsp_next.status      = ovl_pkg::ST_OK;
                    rsp_next.found_value = '0;
                    case (cmd_reg)
                        ovl_pkg::CMD_APPEND:
                        begin
                            if (count_reg >= CW'(DEPTH))
                            begin
                                rsp_next.status = ovl_pkg::ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                            end
                        end
                        ovl_pkg::CMD_DELETE:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_next.status = ovl_pkg::ST_EMPTY;
                            end
                            else if (!any_match)
                            begin
                                rsp_next.status = ovl_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                count_next = count_reg - CW'(1);
                            end
                        end
                        ovl_pkg::CMD_FIND:
                        begin
                            if (count_reg == '0)
                            begin
                                rsp_next.status = ovl_pkg::ST_EMPTY;
                            end
                            else if (KW'(k_reg) >= KW'(count_reg))
                            begin
                                rsp_next.status = ovl_pkg::ST_BOUND;
                            end
                            else
                            begin
                                rsp_next.found_value = found_or;
                            end
                        end
                        default:
                        begin
                            rsp_next.status = ovl_pkg::ST_OK;
                        end
                    endcase
                    rsp_next.entry_total = 5'(count_next);
                    rsp_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= '0;
            item_reg      <= '0;
            k_reg         <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            item_reg      <= item_next;
            k_reg         <= k_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The count never runs past the number of cells.
    `OVL_CHECK(a_count_range, count_reg <= CW'(DEPTH), "entry count exceeds depth")
    // The count moves only on the edge that delivers a result.
    `OVL_CHECK(a_count_on_finish, $stable(count_reg) || $past(finish_go),
        "entry count changed outside a finish")
    // An accepted item goes straight to the compare stage.
    `OVL_CHECK_NEXT(a_accept_exec, accept, state_reg == S_EXEC,
        "accepted item did not enter the compare stage")

endmodule

`default_nettype wire
